// ===== rtl/core/afc_pkg.sv =====
// Shared constants, types and helpers for the AABB frustum culling block.
package afc_pkg;

  localparam int COORD_BITS = 24;
  localparam int PLANE_BITS = 16;
  localparam int COORD_FRAC = 8;
  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int LANE_BITS  = 16;
  localparam int REG_BITS   = 4 * LANE_BITS;
  localparam int CFG_IDX_BITS = $clog2(NUM_PLANES);

  localparam int HALF_BITS  = COORD_BITS - 1;
  localparam int SPAN_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = PLANE_BITS + SPAN_BITS;
  localparam int ACC_BITS   = PROD_BITS + 2;

  localparam int CENTER_LSB = 0;
  localparam int HALF_LSB   = NUM_AXES * COORD_BITS;
  localparam int IN_BITS    = NUM_AXES * (COORD_BITS + HALF_BITS);
  localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = 8;

  localparam int COMP_W = 3;

  typedef logic [REG_BITS-1:0]          plane_reg_t;
  typedef logic signed [PLANE_BITS-1:0] comp_t;
  typedef logic signed [SPAN_BITS-1:0]  span_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  function automatic comp_t plane_comp(plane_reg_t r, int k);
    plane_comp = r[LANE_BITS*k +: PLANE_BITS];
  endfunction

endpackage

// ===== rtl/core/afc_prep.sv =====
// Stage 1: forms center plus and minus half extent per axis.
module afc_prep (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  afc_pkg::ctl_t                                ctl_i,
  input  logic [afc_pkg::NUM_AXES-1:0][afc_pkg::COORD_BITS-1:0] center_i,
  input  logic [afc_pkg::NUM_AXES-1:0][afc_pkg::HALF_BITS-1:0]  half_i,
  output afc_pkg::ctl_t                                ctl_o,
  output afc_pkg::span_t [afc_pkg::NUM_AXES-1:0]       plus_o,
  output afc_pkg::span_t [afc_pkg::NUM_AXES-1:0]       minus_o
);

  afc_pkg::ctl_t ctl_q;
  afc_pkg::span_t [afc_pkg::NUM_AXES-1:0] plus_q, plus_d, minus_q, minus_d;

  always_comb begin
    for (int k = 0; k < afc_pkg::NUM_AXES; k++) begin
      plus_d[k]  = afc_pkg::span_t'($signed(center_i[k])) +
                   afc_pkg::span_t'({1'b0, half_i[k]});
      minus_d[k] = afc_pkg::span_t'($signed(center_i[k])) -
                   afc_pkg::span_t'({1'b0, half_i[k]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plus_q  <= plus_d;
      minus_q <= minus_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign plus_o  = plus_q;
  assign minus_o = minus_q;

endmodule

// ===== rtl/core/afc_mul.sv =====
// Stage 2: one signed product per plane and axis, n*(c-e) or n*(c+e) by sign of n.
module afc_mul (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            en_i,
  input  afc_pkg::ctl_t                                   ctl_i,
  input  afc_pkg::span_t [afc_pkg::NUM_AXES-1:0]          plus_i,
  input  afc_pkg::span_t [afc_pkg::NUM_AXES-1:0]          minus_i,
  input  afc_pkg::plane_reg_t [afc_pkg::NUM_PLANES-1:0]   planes_i,
  output afc_pkg::ctl_t                                   ctl_o,
  output afc_pkg::prod_t [afc_pkg::NUM_PLANES-1:0][afc_pkg::NUM_AXES-1:0] prod_o
);

  afc_pkg::ctl_t ctl_q;
  afc_pkg::prod_t [afc_pkg::NUM_PLANES-1:0][afc_pkg::NUM_AXES-1:0] prod_q, prod_d;

  always_comb begin
    afc_pkg::comp_t n;
    afc_pkg::span_t op;
    for (int j = 0; j < afc_pkg::NUM_PLANES; j++) begin
      for (int k = 0; k < afc_pkg::NUM_AXES; k++) begin
        n  = afc_pkg::plane_comp(planes_i[j], k);
        op = n[afc_pkg::PLANE_BITS-1] ? plus_i[k] : minus_i[k];
        prod_d[j][k] = afc_pkg::prod_t'(n) * afc_pkg::prod_t'(op);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/core/afc_sum.sv =====
// Stage 3: per-plane distance sum with offset, flags planes that reject the box.
module afc_sum (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            en_i,
  input  afc_pkg::ctl_t                                   ctl_i,
  input  afc_pkg::prod_t [afc_pkg::NUM_PLANES-1:0][afc_pkg::NUM_AXES-1:0] prod_i,
  input  afc_pkg::plane_reg_t [afc_pkg::NUM_PLANES-1:0]   planes_i,
  output afc_pkg::ctl_t                                   ctl_o,
  output logic [afc_pkg::NUM_PLANES-1:0]                  outside_o
);

  afc_pkg::ctl_t ctl_q;
  logic [afc_pkg::NUM_PLANES-1:0] outside_q, outside_d;

  always_comb begin
    afc_pkg::acc_t acc;
    for (int j = 0; j < afc_pkg::NUM_PLANES; j++) begin
      acc = afc_pkg::acc_t'(afc_pkg::plane_comp(planes_i[j], afc_pkg::COMP_W))
            <<< afc_pkg::COORD_FRAC;
      for (int k = 0; k < afc_pkg::NUM_AXES; k++) begin
        acc = acc + afc_pkg::acc_t'(prod_i[j][k]);
      end
      outside_d[j] = (acc > afc_pkg::acc_t'(0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      outside_q <= outside_d;
    end
  end

  assign ctl_o     = ctl_q;
  assign outside_o = outside_q;

endmodule

// ===== rtl/core/aabb_frustum_cull.sv =====
// Top level of the six-plane AABB frustum culling pipeline.
//
//  channel  | direction | tdata (low bit up)                            | tlast
//  s_axis   | in        | center_x,y,z (24b each), half_x,y,z (23b each) | box_last
//  m_axis   | out       | visible                                       | result_last
//  cfg      | in        | plane register write, index 0..5             | -
//
// One box per cycle while the output is not stalled; each box passes through the span adders, plane
// multipliers, per-plane sum and compare, and output register in that order.
// All stages advance on one enable: a stalled output holds every stage.
// Reset clears valid bits and loads all planes with zero (every box visible).
module aabb_frustum_cull (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // center_x, center_y, center_z, half_x, half_y, half_z, zero pad
  input  logic [afc_pkg::IN_TDATA_BITS-1:0]       s_axis_tdata,
  input  logic                                    s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // visible, zero pad
  output logic [afc_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata,
  output logic                                    m_axis_tlast,
  input  logic                                    cfg_we_i,
  input  logic [afc_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [afc_pkg::REG_BITS-1:0]            cfg_wdata_i
);

  afc_pkg::plane_reg_t [afc_pkg::NUM_PLANES-1:0] planes_q;

  logic en;
  afc_pkg::ctl_t in_ctl, s1_ctl, s2_ctl, s3_ctl, out_ctl_q;
  logic [afc_pkg::NUM_AXES-1:0][afc_pkg::COORD_BITS-1:0] center;
  logic [afc_pkg::NUM_AXES-1:0][afc_pkg::HALF_BITS-1:0]  half;
  afc_pkg::span_t [afc_pkg::NUM_AXES-1:0] plus, minus;
  afc_pkg::prod_t [afc_pkg::NUM_PLANES-1:0][afc_pkg::NUM_AXES-1:0] prod;
  logic [afc_pkg::NUM_PLANES-1:0] outside;
  logic visible_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_q <= '0;
    end else if (cfg_we_i &&
                 (cfg_index_i < afc_pkg::CFG_IDX_BITS'(afc_pkg::NUM_PLANES))) begin
      planes_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  assign en            = !out_ctl_q.valid || m_axis_tready;
  assign s_axis_tready = en;

  assign in_ctl.valid = s_axis_tvalid;
  assign in_ctl.last  = s_axis_tlast;

  always_comb begin
    for (int k = 0; k < afc_pkg::NUM_AXES; k++) begin
      center[k] = s_axis_tdata[afc_pkg::CENTER_LSB + k*afc_pkg::COORD_BITS +:
                               afc_pkg::COORD_BITS];
      half[k]   = s_axis_tdata[afc_pkg::HALF_LSB + k*afc_pkg::HALF_BITS +:
                               afc_pkg::HALF_BITS];
    end
  end

  afc_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (in_ctl),
    .center_i (center),
    .half_i   (half),
    .ctl_o    (s1_ctl),
    .plus_o   (plus),
    .minus_o  (minus)
  );

  afc_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (s1_ctl),
    .plus_i   (plus),
    .minus_i  (minus),
    .planes_i (planes_q),
    .ctl_o    (s2_ctl),
    .prod_o   (prod)
  );

  afc_sum u_sum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctl_i     (s2_ctl),
    .prod_i    (prod),
    .planes_i  (planes_q),
    .ctl_o     (s3_ctl),
    .outside_o (outside)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ctl_q <= '0;
    end else if (en) begin
      out_ctl_q <= s3_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      visible_q <= ~|outside;
    end
  end

  assign m_axis_tvalid = out_ctl_q.valid;
  assign m_axis_tlast  = out_ctl_q.last;
  assign m_axis_tdata  = {{(afc_pkg::OUT_TDATA_BITS-1){1'b0}}, visible_q};

endmodule
